>>> design/array_list_engine_defines.svh
// Assertion macros for the list engine RTL; only ale_ctrl includes them.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ALE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array_list_engine: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ALE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array_list_engine: next-cycle check failed");

`endif

>>> design/ale_pkg.sv
// Types, constants and helpers for the array list engine.
// No dependencies; used by ale_ctrl and array_list_engine.
package ale_pkg;

  localparam int CAPACITY = 16;
  localparam int ITEM_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port widths fixed by the command format.
  localparam int OP_W     = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int LIMIT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_PW = 5;

  // Compare width that holds a position, a limit and count + 1.
  localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_REAR  = 4'd1,
    OP_SORTED     = 4'd2,
    OP_INSERT_AT  = 4'd3,
    OP_POP_FRONT  = 4'd4,
    OP_POP_REAR   = 4'd5,
    OP_DELETE_AT  = 4'd6,
    OP_DELETE_KEY = 4'd7,
    OP_SEARCH     = 4'd8,
    OP_CLEAR      = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BAD_POS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_DRAIN,
    S_WRITE
  } state_t;

  // One finished command, handed from the sequencer to the result register.
  typedef struct packed {
    logic                      fin;
    status_t                   status;
    logic                      found;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
  } res_t;

  function automatic logic is_insert(op_t op);
    return (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR) ||
           (op == OP_SORTED) || (op == OP_INSERT_AT);
  endfunction

  // Bring a 32-bit input value to the stored item width.
  function automatic logic [ITEM_W-1:0] to_item(logic signed [VALUE_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ITEM_W-1:0];
  endfunction

  // Sign-extend a stored item and keep the low bits of the value field.
  function automatic logic signed [VALUE_W-1:0] to_value(logic [ITEM_W-1:0] v);
    logic signed [63:0] w;
    w = 64'($signed(v));
    return w[VALUE_W-1:0];
  endfunction

endpackage

>>> design/ale_mem.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies; holds the list elements for ale_ctrl.
module ale_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/ale_ctrl.sv
// Command sequencer of the list engine: decode, key scan, slot shifts, count.
// Depends on ale_pkg and array_list_engine_defines.svh; drives the element RAM (ale_mem) through its ports.
`include "array_list_engine_defines.svh"

module ale_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [ale_pkg::OP_W-1:0]           op_in,
  input  logic signed [ale_pkg::VALUE_W-1:0] item_in,
  input  logic [ale_pkg::POS_W-1:0]          position,
  input  logic [ale_pkg::CNT_W-1:0]          limit,
  output logic                               busy,
  output ale_pkg::res_t                      res,
  output logic                               mem_we,
  output logic [ale_pkg::ADDR_W-1:0]         mem_waddr,
  output logic [ale_pkg::ITEM_W-1:0]         mem_wdata,
  output logic [ale_pkg::ADDR_W-1:0]         mem_raddr,
  input  logic [ale_pkg::ITEM_W-1:0]         mem_rdata
);

  localparam int CW  = ale_pkg::CNT_W;
  localparam int MW  = ale_pkg::CMP_W;
  localparam int AW  = ale_pkg::ADDR_W;

  ale_pkg::state_t             state_r, state_nxt;
  ale_pkg::op_t                op_r, op_nxt, op_c;
  logic [ale_pkg::ITEM_W-1:0]  item_r, item_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               src_r, src_nxt;
  logic [CW-1:0]               dst_r, dst_nxt;
  logic [CW-1:0]               cmp_r, cmp_nxt;
  logic                        pend_r, pend_nxt;
  logic                        done_iss_r, done_iss_nxt;

  logic [CW-1:0]               cnt_m1, cnt_p1, pos_idx;
  logic [MW-1:0]               cnt_c, pos_c;
  logic                        full, ins_pos_ok, del_pos_ok, hit, resolve;

  ale_pkg::state_t             dec_tgt;
  logic [CW-1:0]               dec_idx;
  ale_pkg::status_t            dec_status;
  logic                        dec_found;
  logic [CW-1:0]               dec_cnt;

  assign op_c       = ale_pkg::op_t'(op_in);
  assign cnt_m1     = count_r - CW'(1);
  assign cnt_p1     = count_r + CW'(1);
  assign cnt_c      = MW'(count_r);
  assign pos_c      = MW'(position);
  assign pos_idx    = CW'(pos_c - MW'(1));
  assign full       = count_r >= limit;
  assign ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + MW'(1));
  assign del_pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
  assign busy       = (state_r != ale_pkg::S_IDLE);

  // Compare the word read last cycle; sorted insert stops at the first not-less item.
  assign hit = (op_r == ale_pkg::OP_SORTED) ? !($signed(mem_rdata) < $signed(item_r))
                                            : (mem_rdata == item_r);
  assign resolve = pend_r && (hit || done_iss_r);

  // Decide where a new command, or a finished scan, goes next.
  always_comb begin : decode
    dec_tgt    = ale_pkg::S_IDLE;
    dec_idx    = '0;
    dec_status = ale_pkg::STS_DONE;
    dec_found  = 1'b0;
    dec_cnt    = count_r;
    unique case (state_r)
      ale_pkg::S_IDLE: begin
        unique case (op_c)
          ale_pkg::OP_PUSH_FRONT, ale_pkg::OP_PUSH_REAR,
          ale_pkg::OP_SORTED, ale_pkg::OP_INSERT_AT: begin
            priority if (full) begin
              dec_status = ale_pkg::STS_FULL;
            end else if (op_c == ale_pkg::OP_SORTED && count_r != '0) begin
              dec_tgt = ale_pkg::S_SCAN;
            end else if (op_c == ale_pkg::OP_INSERT_AT && !ins_pos_ok) begin
              dec_status = ale_pkg::STS_BAD_POS;
            end else begin
              if (op_c == ale_pkg::OP_PUSH_REAR) dec_idx = count_r;
              else if (op_c == ale_pkg::OP_INSERT_AT) dec_idx = pos_idx;
              else dec_idx = '0;
              dec_tgt = (count_r > dec_idx) ? ale_pkg::S_SHUP : ale_pkg::S_WRITE;
            end
          end
          ale_pkg::OP_POP_FRONT, ale_pkg::OP_POP_REAR, ale_pkg::OP_DELETE_AT: begin
            priority if (count_r == '0) begin
              dec_status = ale_pkg::STS_EMPTY;
            end else if (op_c == ale_pkg::OP_DELETE_AT && !del_pos_ok) begin
              dec_status = ale_pkg::STS_BAD_POS;
            end else begin
              if (op_c == ale_pkg::OP_POP_REAR) dec_idx = cnt_m1;
              else if (op_c == ale_pkg::OP_DELETE_AT) dec_idx = pos_idx;
              else dec_idx = '0;
              if (MW'(dec_idx) + MW'(1) < cnt_c) dec_tgt = ale_pkg::S_SHDN;
              else dec_cnt = cnt_m1;
            end
          end
          ale_pkg::OP_DELETE_KEY: begin
            if (count_r == '0) dec_status = ale_pkg::STS_EMPTY;
            else dec_tgt = ale_pkg::S_SCAN;
          end
          ale_pkg::OP_SEARCH: begin
            if (count_r == '0) dec_status = ale_pkg::STS_NOT_FOUND;
            else dec_tgt = ale_pkg::S_SCAN;
          end
          ale_pkg::OP_CLEAR: begin
            dec_cnt = '0;
          end
          default: begin
          end
        endcase
      end
      ale_pkg::S_SCAN: begin
        if (!resolve) begin
          dec_tgt = ale_pkg::S_SCAN;
        end else begin
          unique case (op_r)
            ale_pkg::OP_SORTED: begin
              dec_idx = hit ? cmp_r : count_r;
              dec_tgt = (count_r > dec_idx) ? ale_pkg::S_SHUP : ale_pkg::S_WRITE;
            end
            ale_pkg::OP_DELETE_KEY: begin
              if (!hit) begin
                dec_status = ale_pkg::STS_NOT_FOUND;
              end else begin
                dec_idx   = cmp_r;
                dec_found = 1'b1;
                if (MW'(cmp_r) + MW'(1) < cnt_c) dec_tgt = ale_pkg::S_SHDN;
                else dec_cnt = cnt_m1;
              end
            end
            default: begin
              if (hit) dec_found = 1'b1;
              else dec_status = ale_pkg::STS_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin : next_state
    state_nxt = state_r;
    unique case (state_r)
      ale_pkg::S_IDLE:  if (start) state_nxt = dec_tgt;
      ale_pkg::S_SCAN:  state_nxt = dec_tgt;
      ale_pkg::S_SHUP:  if (src_r == idx_r) state_nxt = ale_pkg::S_DRAIN;
      ale_pkg::S_SHDN:  if (src_r == cnt_m1) state_nxt = ale_pkg::S_DRAIN;
      ale_pkg::S_DRAIN: state_nxt = ale_pkg::is_insert(op_r) ? ale_pkg::S_WRITE
                                                             : ale_pkg::S_IDLE;
      ale_pkg::S_WRITE: state_nxt = ale_pkg::S_IDLE;
      default:          state_nxt = ale_pkg::S_IDLE;
    endcase
  end

  always_comb begin : datapath
    op_nxt       = op_r;
    item_nxt     = item_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    cmp_nxt      = cmp_r;
    pend_nxt     = pend_r;
    done_iss_nxt = done_iss_r;
    mem_we       = 1'b0;
    mem_waddr    = dst_r[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = src_r[AW-1:0];
    res.fin      = 1'b0;
    res.status   = dec_status;
    res.found    = dec_found;
    res.value    = dec_found ? ale_pkg::to_value(item_r) : '0;
    unique case (state_r)
      ale_pkg::S_IDLE: begin
        if (start) begin
          op_nxt       = op_c;
          item_nxt     = ale_pkg::to_item(item_in);
          idx_nxt      = dec_idx;
          pend_nxt     = 1'b0;
          done_iss_nxt = 1'b0;
          if (dec_tgt == ale_pkg::S_SHUP) src_nxt = cnt_m1;
          else if (dec_tgt == ale_pkg::S_SHDN) src_nxt = dec_idx + CW'(1);
          else src_nxt = '0;
          if (dec_tgt == ale_pkg::S_IDLE) begin
            count_nxt = dec_cnt;
            res.fin   = 1'b1;
          end
        end
      end
      ale_pkg::S_SCAN: begin
        if (resolve) begin
          idx_nxt  = dec_idx;
          pend_nxt = 1'b0;
          if (dec_tgt == ale_pkg::S_SHUP) src_nxt = cnt_m1;
          else src_nxt = dec_idx + CW'(1);
          if (dec_tgt == ale_pkg::S_IDLE) begin
            count_nxt = dec_cnt;
            res.fin   = 1'b1;
          end
        end else begin
          // Issue the next read; its word is compared next cycle.
          pend_nxt = 1'b1;
          cmp_nxt  = src_r;
          if (src_r == cnt_m1) done_iss_nxt = 1'b1;
          else src_nxt = src_r + CW'(1);
        end
      end
      ale_pkg::S_SHUP: begin
        mem_we   = pend_r;
        pend_nxt = 1'b1;
        dst_nxt  = src_r + CW'(1);
        if (src_r != idx_r) src_nxt = src_r - CW'(1);
      end
      ale_pkg::S_SHDN: begin
        mem_we   = pend_r;
        pend_nxt = 1'b1;
        dst_nxt  = src_r - CW'(1);
        if (src_r != cnt_m1) src_nxt = src_r + CW'(1);
      end
      ale_pkg::S_DRAIN: begin
        mem_we   = 1'b1;
        pend_nxt = 1'b0;
        if (!ale_pkg::is_insert(op_r)) begin
          count_nxt  = cnt_m1;
          res.fin    = 1'b1;
          res.status = ale_pkg::STS_DONE;
          res.found  = (op_r == ale_pkg::OP_DELETE_KEY);
          res.value  = (op_r == ale_pkg::OP_DELETE_KEY) ? ale_pkg::to_value(item_r) : '0;
        end
      end
      ale_pkg::S_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_r[AW-1:0];
        mem_wdata  = item_r;
        count_nxt  = cnt_p1;
        res.fin    = 1'b1;
        res.status = ale_pkg::STS_DONE;
        res.found  = 1'b0;
        res.value  = '0;
      end
      default: begin
      end
    endcase
    // Report the count as it stands after this command.
    res.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ale_pkg::S_IDLE;
      count_r    <= '0;
      pend_r     <= 1'b0;
      done_iss_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      done_iss_r <= done_iss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    cmp_r  <= cmp_nxt;
  end

  `ALE_ASSERT_NOW(a_count_cap, 1'b1, count_r <= ale_pkg::CAPACITY)
  `ALE_ASSERT_NOW(a_write_busy, mem_we, state_r != ale_pkg::S_IDLE)
  `ALE_ASSERT_NEXT(a_fin_idle, res.fin, state_r == ale_pkg::S_IDLE)
  `ALE_ASSERT_NEXT(a_count_hold, !res.fin, $stable(count_r))

endmodule

>>> design/array_list_engine.sv
// Top level of the fixed-capacity list engine: limit register, result register.
// Depends on ale_pkg, ale_mem and ale_ctrl.
//
//   channel   ports                                   transfer when
//   command   start, busy, in_op, in_item, in_position  start & !busy
//   result    out_strobe, out_status, out_found,      out_strobe (one cycle)
//             out_value, out_item_count
//   config    cfg_valid, cfg_ready, cfg_data          cfg_valid & cfg_ready
//
// Commands that only check or clear report in the cycle after the transfer.
// push_rear goes straight to the write state; shifting inserts copy entries from the
// slot (from 0) up, drain, write; shifting deletes copy later ones down and drain;
// a key scan reads one entry a cycle, with busy high until the result strobe.
// Synchronous reset empties the list and sets the limit to 16; RAM contents persist.
// The receiver cannot stall: each result shows for exactly one cycle.
module array_list_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ale_pkg::OP_W-1:0]            in_op,
  input  logic signed [ale_pkg::VALUE_W-1:0]  in_item,
  input  logic [ale_pkg::POS_W-1:0]           in_position,
  output logic                                out_strobe,
  output logic [ale_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_found,
  output logic signed [ale_pkg::VALUE_W-1:0]  out_value,
  output logic [ale_pkg::COUNT_PW-1:0]        out_item_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ale_pkg::LIMIT_W-1:0]         cfg_data
);

  localparam int CW = ale_pkg::CNT_W;
  localparam int MW = ale_pkg::CMP_W;

  logic [ale_pkg::LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [CW-1:0]                eff_limit;
  ale_pkg::res_t                res;

  logic                         mem_we;
  logic [ale_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [ale_pkg::ITEM_W-1:0]   mem_wdata, mem_rdata;

  logic                         strobe_r;
  logic [ale_pkg::STATUS_W-1:0] status_r;
  logic                         found_r;
  logic signed [ale_pkg::VALUE_W-1:0] value_r;
  logic [ale_pkg::COUNT_PW-1:0] count_r;

  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  // Saturate the limit to the storage depth.
  assign eff_limit = (MW'(limit_r) > MW'(ale_pkg::CAPACITY)) ? CW'(ale_pkg::CAPACITY)
                                                            : CW'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= ale_pkg::LIMIT_RESET;
      strobe_r <= 1'b0;
    end else begin
      limit_r  <= limit_nxt;
      strobe_r <= res.fin;
    end
  end

  // Hold the payload of the last finished command.
  always_ff @(posedge clk) begin
    if (res.fin) begin
      status_r <= res.status;
      found_r  <= res.found;
      value_r  <= res.value;
      count_r  <= ale_pkg::COUNT_PW'(res.count);
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_found      = found_r;
  assign out_value      = value_r;
  assign out_item_count = count_r;

  ale_mem #(
    .DEPTH (ale_pkg::CAPACITY),
    .WIDTH (ale_pkg::ITEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_in     (in_op),
    .item_in   (in_item),
    .position  (in_position),
    .limit     (eff_limit),
    .busy      (busy),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
